[sv/vgs_pkg.sv]
// Package of shared types and constants for the VEGAS grid sampler.
package vgs_pkg;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 88;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [24:0] ONE_Q24  = 25'h100_0000;
  localparam logic [24:0] HALF_Q24 = 25'h080_0000;
  localparam logic [47:0] W_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] W_ONE    = 48'h00_0001_00_0000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FRAC,
    S_READ,
    S_DELTA,
    S_COORD,
    S_MUL,
    S_ACC,
    S_DONE
  } vgs_state_t;

  typedef struct packed {
    logic       load_wr;
    logic       capture;
    logic       calc_frac;
    logic       read_tbl;
    logic       calc_delta;
    logic       calc_coord;
    logic       mul_clear;
    logic       mul_step;
    logic [1:0] mul_sel;
    logic       mul_acc;
    logic       finish;
  } vgs_cmd_t;

  typedef struct packed {
    logic in_is_sample;
    logic out_free;
  } vgs_status_t;

endpackage

[sv/vegas_grid_sampler_top.sv]
// Top level of the VEGAS importance-grid sampler.
//
// The input stream carries two kinds of transaction, told apart by s_tuser.
// A load transaction (s_tuser low) writes one Q1.24 bin upper boundary into
// the per-dimension grid table and gives no result.
// A sample transaction (s_tuser high) carries a uniform fraction and yields
// one output transaction: the dimension, the chosen bin, the interpolated
// coordinate, the running event weight (Q24.24), last-dimension on m_tlast
// and a sticky saturation flag on m_tuser.
// A sample is registered on acceptance, then steps through bin selection,
// a two-port table read, the bin width, the interpolation multiply, four
// partial products of the 48-bit weight times the factor, and an accumulate.
// The result is written to the output register in the done state, and the
// next transaction is taken only after that: the sequential weight multiply
// sets the pace of samples, while a load leaves the block idle and ready.
// If the receiver stalls, the result holds in the output register; the block
// still accepts loads and the next sample, and waits before finishing that
// sample until the register is free.
// Reset is synchronous and active high: it clears the control state, sets
// the weight to 1.0 and dims_in_use to 1. The grid table is not cleared and
// must be loaded before samples are sent.
module vegas_grid_sampler_top
  import vgs_pkg::*;
#(
  parameter int BIN_COUNT = 64,
  parameter int MAX_DIMS  = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // dims_in_use register write.
  input  logic                   cfg_we,
  input  logic [3:0]             cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // s_tdata fields from bit 0: load_dim[2:0], load_slot[8:3], datum[33:9], zero fill.
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // s_tuser fields from bit 0: opcode.
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // m_tdata fields from bit 0: sample_dim[2:0], bin_index[8:3], coordinate[33:9],
  // event_weight[81:34], zero fill.
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // m_tlast: last_dim.
  output logic                   m_tlast,
  // m_tuser fields from bit 0: weight_saturated.
  output logic                   m_tuser
);

  vgs_cmd_t    cmd;
  vgs_status_t status;

  vgs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  vgs_datapath #(
    .BIN_COUNT (BIN_COUNT),
    .MAX_DIMS  (MAX_DIMS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

[sv/vgs_ctrl.sv]
// Controller state machine that sequences one sample through the datapath.
module vgs_ctrl
  import vgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  vgs_status_t status,
  output vgs_cmd_t    cmd
);

  vgs_state_t state;
  vgs_state_t state_next;
  logic [1:0] mul_cnt;
  logic [1:0] mul_cnt_next;
  logic       fire;

  assign fire = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      mul_cnt <= '0;
    end else begin
      state   <= state_next;
      mul_cnt <= mul_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    mul_cnt_next = '0;
    unique case (state)
      S_IDLE: begin
        if (fire && status.in_is_sample) begin
          state_next = S_FRAC;
        end
      end
      S_FRAC:  state_next = S_READ;
      S_READ:  state_next = S_DELTA;
      S_DELTA: state_next = S_COORD;
      S_COORD: state_next = S_MUL;
      S_MUL: begin
        mul_cnt_next = mul_cnt + 2'd1;
        if (mul_cnt == 2'd3) begin
          state_next = S_ACC;
        end
      end
      S_ACC: state_next = S_DONE;
      S_DONE: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready       = (state == S_IDLE);
    cmd            = '0;
    cmd.load_wr    = fire && !status.in_is_sample;
    cmd.capture    = fire && status.in_is_sample;
    cmd.calc_frac  = (state == S_FRAC);
    cmd.read_tbl   = (state == S_READ);
    cmd.calc_delta = (state == S_DELTA);
    cmd.calc_coord = (state == S_COORD);
    cmd.mul_clear  = (state == S_COORD);
    cmd.mul_step   = (state == S_MUL);
    cmd.mul_sel    = mul_cnt;
    cmd.mul_acc    = ((state == S_MUL) && (mul_cnt != 2'd0)) || (state == S_ACC);
    cmd.finish     = (state == S_DONE) && status.out_free;
  end

endmodule

[sv/vgs_datapath.sv]
// Datapath: boundary table, bin selection, coordinate and weight arithmetic.
module vgs_datapath
  import vgs_pkg::*;
#(
  parameter int BIN_COUNT = 64,
  parameter int MAX_DIMS  = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [3:0]             cfg_wdata,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tuser,
  input  vgs_cmd_t               cmd,
  output vgs_status_t            status,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast,
  output logic                   m_tuser
);

  localparam int BIW   = $clog2(BIN_COUNT);
  localparam int BPW   = $clog2(BIN_COUNT + 1);
  localparam int PWID  = 24 + BPW;
  localparam int FW    = 25 + BIW;
  localparam int FH    = (FW + 1) / 2;
  localparam int PPW   = 24 + FH;
  localparam int PW    = 48 + FW;
  localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DEPTH = MAX_DIMS * BIN_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [7:0] MAX_DIMS_8 = 8'(MAX_DIMS);

  // Input fields.
  logic [2:0]  load_dim;
  logic [5:0]  load_slot;
  logic [24:0] datum;
  logic        load_ok;
  logic [AW-1:0] wr_addr;

  assign load_dim  = s_tdata[2:0];
  assign load_slot = s_tdata[8:3];
  assign datum     = s_tdata[33:9];
  assign load_ok   = (32'(load_dim) < MAX_DIMS) && (32'(load_slot) < BIN_COUNT);
  assign wr_addr   = AW'(32'(load_dim) * BIN_COUNT + 32'(load_slot));

  // Architectural state.
  logic [3:0]    dims_in_use;
  logic [DW-1:0] dim_counter;
  logic [47:0]   weight_acc;
  logic          sat_seen;

  // Working registers.
  logic [24:0]    r_q;
  logic [BIW-1:0] bin_q;
  logic [24:0]    frac_q;
  logic [24:0]    rd_lo;
  logic [24:0]    rd_hi;
  logic [24:0]    x_ini_q;
  logic [24:0]    mag_q;
  logic           neg_q;
  logic [FW-1:0]  factor_q;
  logic [25:0]    step_q;
  logic [PPW-1:0] pp_q;
  logic [1:0]     sh_q;
  logic [PW-1:0]  acc_q;

  logic [24:0] tbl [DEPTH];

  // Bin and sub-bin fraction.
  logic [24:0]     r_sat;
  logic [24:0]     u;
  logic [PWID-1:0] p_full;
  logic [BPW-1:0]  bin_raw;
  logic [BIW-1:0]  bin_c;
  logic [24:0]     frac_c;

  always_comb begin
    r_sat   = (r_q > ONE_Q24) ? ONE_Q24 : r_q;
    u       = ONE_Q24 - r_sat;
    p_full  = PWID'(u) * PWID'(BIN_COUNT);
    bin_raw = p_full[PWID-1:24];
    if (bin_raw >= BPW'(BIN_COUNT)) begin
      bin_c  = BIW'(BIN_COUNT - 1);
      frac_c = ONE_Q24;
    end else begin
      bin_c  = BIW'(bin_raw);
      frac_c = {1'b0, p_full[23:0]};
    end
  end

  // Table addresses of the bin's upper and lower edge.
  logic [AW-1:0] addr_hi;
  logic [AW-1:0] addr_lo;

  assign addr_hi = AW'(AW'(dim_counter) * AW'(BIN_COUNT)) + AW'(bin_q);
  assign addr_lo = addr_hi - AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.load_wr && load_ok) begin
      tbl[wr_addr] <= datum;
    end
    if (cmd.read_tbl) begin
      rd_hi <= tbl[addr_hi];
      rd_lo <= tbl[addr_lo];
    end
  end

  // Bin width.
  logic [24:0] x_ini_c;
  logic        neg_c;
  logic [24:0] mag_c;

  always_comb begin
    x_ini_c = (bin_q == '0) ? 25'd0 : rd_lo;
    neg_c   = rd_hi < x_ini_c;
    mag_c   = neg_c ? (x_ini_c - rd_hi) : (rd_hi - x_ini_c);
  end

  // Interpolation step, rounded to nearest.
  logic [49:0] coord_prod;
  assign coord_prod = 50'(mag_q) * 50'(frac_q) + 50'(HALF_Q24);

  // Weight product: four partial products of a 24-bit weight half and a factor half.
  logic [47:0]    w_op;
  logic [23:0]    w_part;
  logic [FH-1:0]  f_part;
  logic [PW-1:0]  pp_sh;

  always_comb begin
    w_op   = (dim_counter == '0) ? W_ONE : weight_acc;
    w_part = cmd.mul_sel[1] ? w_op[47:24] : w_op[23:0];
    f_part = cmd.mul_sel[0] ? FH'(factor_q >> FH) : factor_q[FH-1:0];
    unique case (sh_q)
      2'd0:    pp_sh = PW'(pp_q);
      2'd1:    pp_sh = PW'(pp_q) << FH;
      2'd2:    pp_sh = PW'(pp_q) << 24;
      default: pp_sh = PW'(pp_q) << (24 + FH);
    endcase
  end

  // Result assembly.
  logic [25:0] coord_w;
  logic [24:0] coord_c;
  logic        ovf;
  logic [47:0] w_new;
  logic        sat_new;
  logic [7:0]  eff;
  logic        last_c;

  always_comb begin
    if (neg_q) begin
      coord_w = (step_q > 26'(x_ini_q)) ? 26'd0 : 26'(x_ini_q) - step_q;
    end else begin
      coord_w = 26'(x_ini_q) + step_q;
    end
    coord_c = (coord_w > 26'(ONE_Q24)) ? ONE_Q24 : coord_w[24:0];
    ovf     = |acc_q[PW-1:72];
    w_new   = ovf ? W_MAX : acc_q[71:24];
    sat_new = ((dim_counter == '0) ? 1'b0 : sat_seen) | ovf;
    if (dims_in_use == 4'd0) begin
      eff = 8'd1;
    end else if (8'(dims_in_use) > MAX_DIMS_8) begin
      eff = MAX_DIMS_8;
    end else begin
      eff = 8'(dims_in_use);
    end
    last_c = (8'(dim_counter) + 8'd1) >= eff;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_q <= datum;
    end
    if (cmd.calc_frac) begin
      bin_q  <= bin_c;
      frac_q <= frac_c;
    end
    if (cmd.calc_delta) begin
      x_ini_q  <= x_ini_c;
      neg_q    <= neg_c;
      mag_q    <= mag_c;
      factor_q <= neg_c ? '0 : FW'(mag_c) * FW'(BIN_COUNT);
    end
    if (cmd.calc_coord) begin
      step_q <= coord_prod[49:24];
    end
    if (cmd.mul_step) begin
      pp_q <= PPW'(w_part) * PPW'(f_part);
      sh_q <= cmd.mul_sel;
    end
    if (cmd.mul_clear) begin
      acc_q <= '0;
    end else if (cmd.mul_acc) begin
      acc_q <= acc_q + pp_sh;
    end
  end

  // Control state and output register.
  logic [2:0]  out_dim;
  logic [5:0]  out_bin;
  logic [24:0] out_coord;
  logic [47:0] out_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= 4'd1;
      dim_counter <= '0;
      weight_acc  <= W_ONE;
      sat_seen    <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        dims_in_use <= cfg_wdata;
      end
      if (cmd.finish) begin
        weight_acc  <= w_new;
        sat_seen    <= sat_new;
        dim_counter <= last_c ? '0 : dim_counter + DW'(1);
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_dim    <= 3'(dim_counter);
      out_bin    <= 6'(bin_q);
      out_coord  <= coord_c;
      out_weight <= w_new;
      m_tlast    <= last_c;
      m_tuser    <= sat_new;
    end
  end

  assign m_tdata = {6'd0, out_weight, out_coord, out_bin, out_dim};

  assign status.in_is_sample = (s_tuser == OP_SAMPLE);
  assign status.out_free     = !m_tvalid || m_tready;

endmodule

[sv/vgs_checker.sv]
// Port-level checker for the VEGAS grid sampler and its bind statement.
module vgs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Reset empties the output register.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A sample transaction occupies the datapath, so input stalls next cycle.
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input ready right after a sample");

  // A load completes in its own cycle and keeps input ready.
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> s_tready)
    else $error("input stalled after a load");

endmodule

bind vegas_grid_sampler_top vgs_checker u_vgs_checker (.*);

[verif/tb_top.sv]
// Self-checking testbench for the VEGAS grid sampler: directed and random streams.
`timescale 1ns / 1ps

module tb_top;
  import vgs_pkg::*;

  localparam int     BIN_COUNT     = 64;
  localparam int     MAX_DIMS      = 8;
  localparam int     CLK_PERIOD    = 12;
  localparam int     RESET_CYCLES  = 7;
  // Extra wait after the last owed result, so that the block settles.
  localparam int     SETTLE_CYCLES = 16;
  localparam int     LOAD_SHARE    = 20;
  localparam int     HOLD_CYCLES   = 240;
  // Watchdog limit, several times the slowest legal run of this sequence.
  localparam longint TIMEOUT_NS    = 64'd7_200_000;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_style_t;

  typedef struct packed {
    logic [2:0]  dim;
    logic [5:0]  bin;
    logic [24:0] coord;
    logic [47:0] weight;
    logic        last;
    logic        sat;
  } sample_result_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [3:0]             cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;

  // Predictor state: the grid as the block should hold it, plus the event state.
  logic [24:0] grid_bound [MAX_DIMS][BIN_COUNT];
  logic [2:0]  dim_ctr_model = 3'd0;
  logic [47:0] weight_model  = W_ONE;
  logic        sat_model     = 1'b0;
  logic [3:0]  dims_model    = 4'd1;

  // Results owed by the block, oldest first.
  sample_result_t samples_due[$];

  int          mismatches = 0;
  int          burst_left = 0;
  bit          tx_steady  = 1'b0;
  rx_style_t   rx_style   = RX_ALWAYS;
  logic [15:0] rx_mask    = 16'hFFFF;
  int          hold_req   = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  vegas_grid_sampler_top #(
    .BIN_COUNT(BIN_COUNT),
    .MAX_DIMS (MAX_DIMS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Applies one accepted transaction to the predictor. A load updates the grid;
  // a sample picks a bin, interpolates inside it and scales the event weight.
  function automatic void compute_sample(input logic op, input logic [2:0] ld,
                                         input logic [5:0] ls, input logic [24:0] datum);
    logic [24:0]    r;
    logic [30:0]    pos;
    logic [6:0]     bin;
    logic [24:0]    frac;
    logic [63:0]    x_ini, x_end, mag, step_amt, coord, factor, prod;
    logic           neg, last;
    int             eff;
    sample_result_t res;
    if (op == OP_LOAD) begin
      grid_bound[ld][ls] = datum;
      return;
    end
    eff = (dims_model == 0) ? 1 : (dims_model > MAX_DIMS) ? MAX_DIMS : int'(dims_model);
    r = (datum > ONE_Q24) ? ONE_Q24 : datum;
    pos = (31'(ONE_Q24) - 31'(r)) * 31'(BIN_COUNT);
    bin = pos[30:24];
    frac = {1'b0, pos[23:0]};
    // A zero fraction lands one past the top bin; it folds back with a full fraction.
    if (bin >= BIN_COUNT) begin
      bin = 7'(BIN_COUNT - 1);
      frac = ONE_Q24;
    end
    x_ini = (bin > 0) ? 64'(grid_bound[dim_ctr_model][bin - 1]) : 64'd0;
    x_end = 64'(grid_bound[dim_ctr_model][bin]);
    neg = x_end < x_ini;
    mag = neg ? x_ini - x_end : x_end - x_ini;
    step_amt = (mag * 64'(frac) + 64'(HALF_Q24)) >> 24;
    if (neg) begin
      coord = (step_amt > x_ini) ? 64'd0 : x_ini - step_amt;
    end else begin
      coord = x_ini + step_amt;
    end
    if (coord > 64'(ONE_Q24)) coord = 64'(ONE_Q24);
    if (dim_ctr_model == 0) begin
      weight_model = W_ONE;
      sat_model = 1'b0;
    end
    // A bin of negative width contributes a zero weight factor.
    factor = neg ? 64'd0 : mag * BIN_COUNT;
    prod = 64'(weight_model[47:24]) * factor
         + ((64'(weight_model[23:0]) * factor) >> 24);
    if (prod > 64'(W_MAX)) begin
      prod = 64'(W_MAX);
      sat_model = 1'b1;
    end
    weight_model = prod[47:0];
    last = (int'(dim_ctr_model) + 1) >= eff;
    res.dim = dim_ctr_model;
    res.bin = bin[5:0];
    res.coord = coord[24:0];
    res.weight = weight_model;
    res.last = last;
    res.sat = sat_model;
    samples_due.push_back(res);
    dim_ctr_model = last ? 3'd0 : dim_ctr_model + 3'd1;
  endfunction

  function automatic void check_field(input string label, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, label, want, got);
      mismatches++;
    end
  endfunction

  // Every result transaction is matched against the oldest owed sample.
  always @(posedge clk) begin : result_checker
    sample_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (samples_due.size() == 0) begin
        $display("%0t: result transaction, expected none, got tdata 0x%0h", $time, m_tdata);
        mismatches++;
      end else begin
        want = samples_due.pop_front();
        check_field("sample_dim", want.dim, m_tdata[2:0]);
        check_field("bin_index", want.bin, m_tdata[8:3]);
        check_field("coordinate", want.coord, m_tdata[33:9]);
        check_field("event_weight", want.weight, m_tdata[81:34]);
        check_field("last_dim", want.last, m_tlast);
        check_field("weight_saturated", want.sat, m_tuser);
      end
    end
  end

  // The receiver follows the style of the current phase; a hold request
  // overrides it and keeps tready low until the requested hold has run out.
  initial begin : receiver
    int hold_left;
    int beat;
    hold_left = 0;
    beat = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      beat++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        case (rx_style)
          RX_ALWAYS: m_tready = 1'b1;
          RX_RANDOM: m_tready = ($urandom_range(99) < 65);
          default:   m_tready = rx_mask[beat % 16];
        endcase
      end
    end
  end

  // Offers one transaction and holds it until accepted. Unless the sender is
  // steady, a burst of random length ends with a random gap.
  task automatic send_item(input logic op, input logic [2:0] ld, input logic [5:0] ls,
                           input logic [24:0] datum);
    int gap;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = {6'd0, datum, ls, ld};
    do @(posedge clk); while (!s_tready);
    compute_sample(op, ld, ls, datum);
    if (!tx_steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(15, 1);
        burst_left = $urandom_range(12);
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Stops offering and waits until the block owes nothing and has settled.
  task automatic wait_for_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dims(input logic [3:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    dims_model = value;
  endtask

  // A monotone boundary near the uniform grid; the last slot is exactly 1.0.
  function automatic logic [24:0] tidy_bound(input int slot);
    int jitter;
    jitter = int'($urandom_range(1 << 17)) - (1 << 16);
    if (slot == BIN_COUNT - 1) return ONE_Q24;
    return 25'((slot + 1) * (int'(ONE_Q24) / BIN_COUNT) + jitter);
  endfunction

  function automatic logic [24:0] pick_boundary(input int slot);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return tidy_bound(slot);
      6, 7, 8:          return 25'($urandom_range(int'(ONE_Q24)));
      default:          return ($urandom_range(1) != 0) ? ONE_Q24 : 25'd0;
    endcase
  endfunction

  // Mostly uniform fractions, with the ends of the range and exact bin edges mixed in.
  function automatic logic [24:0] pick_fraction();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0:       return 25'd0;
          1:       return 25'd1;
          2:       return ONE_Q24;
          3:       return ONE_Q24 - 25'd1;
          default: return 25'($urandom_range(BIN_COUNT) * (int'(ONE_Q24) / BIN_COUNT));
        endcase
      end
      default: return 25'($urandom_range(int'(ONE_Q24)));
    endcase
  endfunction

  task automatic random_item(input int load_pct);
    logic [2:0] ld;
    logic [5:0] ls;
    ld = 3'($urandom);
    ls = 6'($urandom);
    if ($urandom_range(99) < load_pct) begin
      send_item(OP_LOAD, ld, ls, pick_boundary(ls));
    end else begin
      send_item(OP_SAMPLE, ld, ls, pick_fraction());
    end
  endtask

  // Every grid entry is written before any sample can read it.
  task automatic test_grid_fill();
    for (int d = 0; d < MAX_DIMS; d++) begin
      for (int s = 0; s < BIN_COUNT; s++) begin
        send_item(OP_LOAD, 3'(d), 6'(s), tidy_bound(s));
      end
    end
  endtask

  // Runs on the reset value of dims_in_use, so every sample closes its event.
  task automatic test_fraction_edges();
    send_item(OP_SAMPLE, 3'd0, 6'd0, ONE_Q24);
    send_item(OP_SAMPLE, 3'd7, 6'd63, 25'd0);
    send_item(OP_SAMPLE, 3'd0, 6'd0, 25'd1);
    send_item(OP_SAMPLE, 3'd5, 6'd21, ONE_Q24 - 25'd1);
    send_item(OP_SAMPLE, 3'd2, 6'd42, HALF_Q24);
    send_item(OP_SAMPLE, 3'd0, 6'd0, ONE_Q24 - (ONE_Q24 >> 6));
  endtask

  // Bin 10 of dimension 0 falls from 1.0 to 0 and bin 11 has zero width.
  // The midpoint sample of bin 10 exercises the downward interpolation.
  task automatic test_negative_width();
    send_item(OP_LOAD, 3'd0, 6'd9, ONE_Q24);
    send_item(OP_LOAD, 3'd0, 6'd10, 25'd0);
    send_item(OP_LOAD, 3'd0, 6'd11, 25'd0);
    send_item(OP_LOAD, 3'd7, 6'd63, 25'd0);
    send_item(OP_SAMPLE, 3'd0, 6'd0, ONE_Q24 - 25'd21 * (ONE_Q24 >> 7));
    send_item(OP_SAMPLE, 3'd0, 6'd0, ONE_Q24 - 25'd23 * (ONE_Q24 >> 7));
  endtask

  // A full-width first bin multiplies the weight by 64 per dimension, so an
  // eight-dimension event clips on its fourth sample and keeps the flag. The
  // extra sample opens a new event and must see the flag cleared.
  task automatic test_weight_saturation();
    write_dims(4'd8);
    for (int d = 0; d < 4; d++) begin
      send_item(OP_LOAD, 3'(d), 6'd0, ONE_Q24);
    end
    repeat (MAX_DIMS + 1) send_item(OP_SAMPLE, 3'd0, 6'd0, ONE_Q24);
  endtask

  // The receiver stops for a long stretch while the sender keeps offering,
  // which fills the output register and stalls the input; then the sender
  // waits for every owed result before going on.
  task automatic test_backpressure();
    wait_for_results();
    hold_req = HOLD_CYCLES;
    tx_steady = 1'b1;
    repeat (40) random_item(LOAD_SHARE);
    tx_steady = 1'b0;
    wait_for_results();
  endtask

  task automatic test_random_traffic(input logic [3:0] dims, input bit steady,
                                     input rx_style_t style, input int count);
    tx_steady = steady;
    rx_style = style;
    rx_mask = 16'($urandom) | 16'h0001;
    write_dims(dims);
    repeat (count) random_item(LOAD_SHARE);
  endtask

  initial begin : test_sequence
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;
    test_grid_fill();
    test_fraction_edges();
    test_negative_width();
    test_weight_saturation();
    test_backpressure();
    // Phases switch dims_in_use without waiting for an event boundary, so the
    // counter carries over into the new setting.
    test_random_traffic(4'd1, 1'b1, RX_ALWAYS, 100);
    test_random_traffic(4'd8, 1'b0, RX_RANDOM, 100);
    test_random_traffic(4'd0, 1'b0, RX_PATTERN, 80);
    test_random_traffic(4'd15, 1'b0, RX_RANDOM, 80);
    test_random_traffic(4'd3, 1'b0, RX_PATTERN, 100);
    test_random_traffic(4'($urandom_range(8, 1)), 1'b0, rx_style_t'($urandom_range(2)), 160);
    wait_for_results();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
